// ===== rtl/dssg_pkg.sv =====
package dssg_pkg;

  // defaults for the top level parameters
  localparam int MAX_INTERVALS_DEF = 30;
  localparam int COORD_WIDTH_DEF   = 16;
  localparam int CORDIC_STEPS_DEF  = 16;

  // configuration register indexes
  localparam logic [1:0] REG_SLICE_COUNT     = 2'd0;
  localparam logic [1:0] REG_INTERVAL_COUNT  = 2'd1;
  localparam logic [1:0] REG_REVERSE_WINDING = 2'd2;

  localparam logic [12:0] SLICE_COUNT_RST    = 13'd16;
  localparam logic [4:0]  INTERVAL_COUNT_RST = 5'd4;

  // phase: 2^32 is one turn
  localparam int PHASE_W = 32;

  // shared restoring divider
  localparam int DIV_NW = 45;            // numerator bits (13-bit slice number << 32)
  localparam int DIV_DW = 13;            // divisor bits
  localparam int DIV_QW = 33;            // quotient bits kept
  localparam int DIV_CW = 6;             // iteration counter

  typedef struct packed {
    logic              start;
    logic [DIV_CW-1:0] cnt;
  } div_ctl_t;

  // CORDIC, Q2.30 values
  localparam int CS_W = 33;
  localparam int ATAN_ENTRIES = 24;
  localparam logic signed [CS_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;
  localparam int HALF_Q30 = 536870912;

  localparam logic signed [31:0] ATAN_TURN [ATAN_ENTRIES] = '{
    32'sd536870912, 32'sd316933405, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335086,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41721,     32'sd20860,
    32'sd10430,     32'sd5215,      32'sd2607,      32'sd1303,
    32'sd651,       32'sd325,       32'sd162,       32'sd81
  };

endpackage

// ===== rtl/dssg_div.sv =====
module dssg_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dssg_pkg::div_ctl_t             ctl,
  input  logic [dssg_pkg::DIV_NW-1:0]    num,
  input  logic [dssg_pkg::DIV_DW-1:0]    den,
  output logic                           done,
  output logic [dssg_pkg::DIV_QW-1:0]    quo
);
  import dssg_pkg::*;

  logic [DIV_NW-1:0] num_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_QW-1:0] q_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [DIV_DW:0] trial;
  logic [DIV_DW:0] sub;
  logic            ge;

  // one quotient bit per cycle, numerator fed MSB first
  assign trial = {rem_r, num_r[DIV_NW-1]};
  assign ge    = (trial >= {1'b0, den});
  assign sub   = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ctl.cnt;
        num_r  <= num;
        rem_r  <= '0;
        q_r    <= '0;
      end else if (busy_r) begin
        num_r <= num_r << 1;
        rem_r <= ge ? sub[DIV_DW-1:0] : trial[DIV_DW-1:0];
        q_r   <= {q_r[DIV_QW-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// ===== rtl/dssg_cordic.sv =====
module dssg_cordic #(
  parameter int CORDIC_STEPS = dssg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [dssg_pkg::PHASE_W-1:0]        phase,
  output logic                                done,
  output logic signed [dssg_pkg::CS_W-1:0]    cos_out,
  output logic signed [dssg_pkg::CS_W-1:0]    sin_out
);
  import dssg_pkg::*;

  logic signed [CS_W-1:0] x_r, y_r;
  logic signed [31:0]     z_r;
  logic [1:0]             quad_r;
  logic [4:0]             i_r;
  logic                   busy_r;
  logic                   done_r;

  logic signed [CS_W-1:0] dx, dy;
  logic signed [31:0]     at;

  assign dx = y_r >>> i_r;
  assign dy = x_r >>> i_r;
  assign at = ATAN_TURN[i_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        x_r    <= CORDIC_GAIN_Q30;
        y_r    <= '0;
        z_r    <= $signed({2'b00, phase[PHASE_W-3:0]});
        quad_r <= phase[PHASE_W-1:PHASE_W-2];
        i_r    <= '0;
      end else if (busy_r) begin
        if (!z_r[31]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + at;
        end
        i_r <= i_r + 1'b1;
        if (i_r == 5'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // quadrant fold
  always_comb begin
    case (quad_r)
      2'd0: begin
        cos_out = x_r;
        sin_out = y_r;
      end
      2'd1: begin
        cos_out = -y_r;
        sin_out = x_r;
      end
      2'd2: begin
        cos_out = -x_r;
        sin_out = -y_r;
      end
      default: begin
        cos_out = y_r;
        sin_out = -x_r;
      end
    endcase
  end

  assign done = done_r;

endmodule

// ===== rtl/disc_slice_strip_generator.sv =====
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  center x/y/z, disc_radius, slice_index
// out      output     out_valid/out_stall vertex x/y/z, strip_end
// cfg      input      APB psel/penable   slice_count, interval_count, reverse_winding
//
// One wedge at a time. Per rim point: a phase division (start, 45 quotient
// bits, handoff), the CORDIC iterations and the MULC, MULS and RIMZ
// multiply/round states. Then four increment divisions on the same shared
// divider and 2*(I+1)+2 vertices at one per cycle while out_stall is low.
// rst_n is synchronous; it restores the register defaults and empties the output.
// out_stall holds the output register and the vertex emission; a new transaction is taken once the
// last vertex is loaded, even if it still waits to be taken.
module disc_slice_strip_generator #(
  parameter int MAX_INTERVALS = dssg_pkg::MAX_INTERVALS_DEF,
  parameter int COORD_WIDTH   = dssg_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS  = dssg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_center_x,
  input  logic signed [COORD_WIDTH-1:0] in_center_y,
  input  logic signed [COORD_WIDTH-1:0] in_center_z,
  input  logic [14:0]                   in_disc_radius,
  input  logic [11:0]                   in_slice_index,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_vertex_x,
  output logic signed [COORD_WIDTH-1:0] out_vertex_y,
  output logic signed [COORD_WIDTH-1:0] out_vertex_z,
  output logic                          out_strip_end,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import dssg_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int WW = ((CW > 16) ? CW : 16) + 2;   // center + rim offset
  localparam int AW = CW + 7;                      // increment * row
  localparam int SW = CW + 8;                      // center + accumulator
  localparam int PW = CS_W + 16;                   // cos/sin * radius

  typedef enum logic [10:0] {
    S_IDLE      = 11'b00000000001,
    S_DIVP_GO   = 11'b00000000010,
    S_DIVP_WAIT = 11'b00000000100,
    S_CORD_WAIT = 11'b00000001000,
    S_MULC      = 11'b00000010000,
    S_MULS      = 11'b00000100000,
    S_RIMZ      = 11'b00001000000,
    S_DIVI_GO   = 11'b00010000000,
    S_DIVI_WAIT = 11'b00100000000,
    S_EMIT      = 11'b01000000000,
    S_TAIL      = 11'b10000000000
  } state_t;

  // ---------------- configuration registers ----------------
  logic [12:0] slice_count_r;
  logic [4:0]  interval_count_r;
  logic        reverse_winding_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_count_r     <= SLICE_COUNT_RST;
      interval_count_r  <= INTERVAL_COUNT_RST;
      reverse_winding_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_SLICE_COUNT:     slice_count_r     <= pwdata[12:0];
        REG_INTERVAL_COUNT:  interval_count_r  <= pwdata[4:0];
        REG_REVERSE_WINDING: reverse_winding_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SLICE_COUNT:     prdata = {19'd0, slice_count_r};
      REG_INTERVAL_COUNT:  prdata = {27'd0, interval_count_r};
      REG_REVERSE_WINDING: prdata = {31'd0, reverse_winding_r};
      default:             prdata = '0;
    endcase
  end

  // ---------------- saturation helpers ----------------
  function automatic logic signed [CW-1:0] sat_w(input logic signed [WW-1:0] v);
    if (&v[WW-1:CW-1] || ~|v[WW-1:CW-1]) sat_w = v[CW-1:0];
    else sat_w = v[WW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  endfunction

  function automatic logic signed [CW-1:0] sat_s(input logic signed [SW-1:0] v);
    if (&v[SW-1:CW-1] || ~|v[SW-1:CW-1]) sat_s = v[CW-1:0];
    else sat_s = v[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  endfunction

  // ---------------- transaction state ----------------
  state_t                 state_r;
  logic                   pt_r;         // 0: rim at k+1, 1: rim at k
  logic [1:0]             idx_r;        // increment being divided {side, axis}
  logic [4:0]             row_r;
  logic                   side_r;       // 0 left, 1 right
  logic                   tail_r;

  logic signed [CW-1:0]   cx_r, cy_r, cz_r;
  logic [14:0]            rad_r;
  logic [11:0]            k_r;
  logic [12:0]            n_r;
  logic [4:0]             iv_r;
  logic                   rev_r;

  logic signed [CW-1:0]   rim_r [2][2];  // [point][x/z]
  logic signed [CW:0]     inc_r [4];     // left x, left z, right x, right z
  logic signed [AW-1:0]   acc_r [4];
  logic signed [PW-1:0]   prod_r;

  logic                   in_acc;
  logic                   load;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid & ~in_stall;

  // effective config, taken at accept
  logic [12:0] n_eff;
  logic [4:0]  iv_eff;
  assign n_eff  = (slice_count_r == 13'd0) ? 13'd1 : slice_count_r;
  assign iv_eff = (interval_count_r == 5'd0) ? 5'd1 :
                  (interval_count_r > 5'(MAX_INTERVALS)) ? 5'(MAX_INTERVALS) :
                  interval_count_r;

  // ---------------- shared divider ----------------
  div_ctl_t           div_ctl;
  logic [DIV_NW-1:0]  div_num;
  logic [DIV_DW-1:0]  div_den;
  logic               div_done;
  logic [DIV_QW-1:0]  div_q;

  logic [DIV_NW-PHASE_W-1:0] slice_m;
  logic                      src_pt;
  logic signed [CW-1:0]      d_rim, d_ctr;
  logic signed [CW:0]        diff;
  logic [CW:0]               mag;
  logic [CW:0]               q_mag;

  // slice number k+1 for the left point, k for the right one
  assign slice_m = pt_r ? (DIV_NW-PHASE_W)'(k_r) : (DIV_NW-PHASE_W)'(k_r) + 1'b1;

  // rim minus center for the increment under way; reverse picks the other point
  assign src_pt = idx_r[1] ^ rev_r;
  assign d_rim  = idx_r[0] ? rim_r[src_pt][1] : rim_r[src_pt][0];
  assign d_ctr  = idx_r[0] ? cz_r : cx_r;
  assign diff   = (CW+1)'(d_rim) - (CW+1)'(d_ctr);
  assign mag    = diff[CW] ? $unsigned(-diff) : $unsigned(diff);
  assign q_mag  = div_q[CW:0];

  always_comb begin
    div_ctl.start = (state_r == S_DIVP_GO) || (state_r == S_DIVI_GO);
    if (state_r == S_DIVI_GO) begin
      div_ctl.cnt = DIV_CW'(CW + 1);
      div_num     = {mag, {(DIV_NW-CW-1){1'b0}}};
    end else begin
      div_ctl.cnt = DIV_CW'(DIV_NW);
      div_num     = {slice_m, {PHASE_W{1'b0}}};
    end
    div_den = (state_r == S_DIVI_GO || state_r == S_DIVI_WAIT) ?
              {{(DIV_DW-5){1'b0}}, iv_r} : n_r;
  end

  dssg_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (div_ctl),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_q)
  );

  // ---------------- CORDIC ----------------
  logic                   cord_start;
  logic                   cord_done;
  logic signed [CS_W-1:0] cos_v, sin_v;

  assign cord_start = (state_r == S_DIVP_WAIT) && div_done;

  dssg_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cord_start),
    .phase  (div_q[PHASE_W-1:0]),
    .done   (cord_done),
    .cos_out(cos_v),
    .sin_out(sin_v)
  );

  // ---------------- rim offset: round half up, add center, saturate ----------------
  logic signed [CS_W-1:0] cs_sel;
  logic signed [PW-1:0]   off_rnd;
  logic signed [PW-1:0]   off_sh;
  logic signed [WW-1:0]   rim_sum;
  logic signed [CW-1:0]   rim_sat;

  assign cs_sel  = (state_r == S_MULC) ? cos_v : sin_v;
  assign off_rnd = prod_r + PW'(HALF_Q30);
  assign off_sh  = off_rnd >>> 30;
  assign rim_sum = WW'((state_r == S_MULS) ? cx_r : cz_r) + off_sh[WW-1:0];
  assign rim_sat = sat_w(rim_sum);

  // ---------------- vertex datapath ----------------
  logic signed [SW-1:0] vx_sum, vz_sum;
  assign vx_sum = SW'(cx_r) + SW'(acc_r[{side_r, 1'b0}]);
  assign vz_sum = SW'(cz_r) + SW'(acc_r[{side_r, 1'b1}]);

  assign load = ~out_valid | ~out_stall;

  logic signed [CW-1:0] out_x_r, out_y_r, out_z_r;
  logic                 out_end_r;
  logic                 out_valid_r;
  logic                 emit_go;

  // a vertex is loaded whenever the register is free in EMIT or TAIL
  assign emit_go = (state_r == S_EMIT) || (state_r == S_TAIL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= emit_go;
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cx_r    <= in_center_x;
            cy_r    <= in_center_y;
            cz_r    <= in_center_z;
            rad_r   <= in_disc_radius;
            k_r     <= in_slice_index;
            n_r     <= n_eff;
            iv_r    <= iv_eff;
            rev_r   <= reverse_winding_r;
            pt_r    <= 1'b0;
            state_r <= S_DIVP_GO;
          end
        end
        S_DIVP_GO:   state_r <= S_DIVP_WAIT;
        S_DIVP_WAIT: if (div_done) state_r <= S_CORD_WAIT;
        S_CORD_WAIT: if (cord_done) state_r <= S_MULC;
        S_MULC: begin
          prod_r  <= cs_sel * $signed({1'b0, rad_r});
          state_r <= S_MULS;
        end
        S_MULS: begin
          rim_r[pt_r][0] <= rim_sat;
          prod_r         <= cs_sel * $signed({1'b0, rad_r});
          state_r        <= S_RIMZ;
        end
        S_RIMZ: begin
          rim_r[pt_r][1] <= rim_sat;
          if (!pt_r) begin
            pt_r    <= 1'b1;
            state_r <= S_DIVP_GO;
          end else begin
            idx_r   <= 2'd0;
            state_r <= S_DIVI_GO;
          end
        end
        S_DIVI_GO: state_r <= S_DIVI_WAIT;
        S_DIVI_WAIT: begin
          if (div_done) begin
            // truncate toward zero: divide magnitudes, restore sign
            inc_r[idx_r] <= diff[CW] ? -$signed(q_mag) : $signed(q_mag);
            if (idx_r == 2'd3) begin
              for (int i = 0; i < 4; i++) acc_r[i] <= '0;
              row_r   <= '0;
              side_r  <= 1'b0;
              state_r <= S_EMIT;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_DIVI_GO;
            end
          end
        end
        S_EMIT: begin
          if (load) begin
            out_x_r     <= sat_s(vx_sum);
            out_y_r     <= cy_r;
            out_z_r     <= sat_s(vz_sum);
            out_end_r   <= 1'b0;
            side_r      <= ~side_r;
            if (side_r) begin
              for (int i = 0; i < 4; i++) acc_r[i] <= acc_r[i] + AW'(inc_r[i]);
              if (row_r == iv_r) begin
                tail_r  <= 1'b0;
                state_r <= S_TAIL;
              end else begin
                row_r <= row_r + 1'b1;
              end
            end
          end
        end
        S_TAIL: begin
          // two center copies close the strip
          if (load) begin
            out_x_r     <= cx_r;
            out_y_r     <= cy_r;
            out_z_r     <= cz_r;
            out_end_r   <= tail_r;
            tail_r      <= 1'b1;
            if (tail_r) state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_vertex_x  = out_x_r;
  assign out_vertex_y  = out_y_r;
  assign out_vertex_z  = out_z_r;
  assign out_strip_end = out_end_r;

endmodule

// ===== sim/dssg_strip_checker.sv =====
module dssg_strip_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] in_center_x,
  input  logic signed [15:0] in_center_y,
  input  logic signed [15:0] in_center_z,
  input  logic [14:0]        in_disc_radius,
  input  logic [11:0]        in_slice_index,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_vertex_x,
  input  logic signed [15:0] out_vertex_y,
  input  logic signed [15:0] out_vertex_z,
  input  logic               out_strip_end,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 mismatch_count,
  output int                 vertices_pending
);
  import dssg_pkg::*;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               strip_end;
  } vertex_t;

  vertex_t     expected_vertices[$];
  logic [12:0] slices;
  logic [4:0]  intervals;
  logic        reverse;

  function automatic longint sat16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // rim point at angle m/n turn, CORDIC in Q2.30
  task automatic rim_point(input longint m, input longint n, input longint cx,
                           input longint cz, input longint rad,
                           output longint rx, output longint rz);
    longint unsigned phase;
    longint x, y, z, dx, dy, c, s;
    phase = ((longint'(m) << 32) / n) & 64'hFFFF_FFFF;
    x = 652032874;
    y = 0;
    z = longint'(phase & 64'h3FFF_FFFF);
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TURN[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TURN[i]);
      end
    end
    case (phase[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    rx = sat16(cx + ((c * rad + HALF_Q30) >>> 30));
    rz = sat16(cz + ((s * rad + HALF_Q30) >>> 30));
  endtask

  task automatic predict_wedge(input longint cx, input longint cy, input longint cz,
                               input longint rad, input longint k);
    longint n, iv, lx, lz, rx, rz, t, ilx, ilz, irx, irz;
    vertex_t v;
    n  = (slices == 0) ? 1 : slices;
    iv = (intervals == 0) ? 1 : (intervals > 30 ? 30 : intervals);
    rim_point(k + 1, n, cx, cz, rad, lx, lz);
    rim_point(k, n, cx, cz, rad, rx, rz);
    if (reverse) begin
      t = lx; lx = rx; rx = t;
      t = lz; lz = rz; rz = t;
    end
    ilx = (lx - cx) / iv;
    ilz = (lz - cz) / iv;
    irx = (rx - cx) / iv;
    irz = (rz - cz) / iv;
    for (longint r = 0; r <= iv; r++) begin
      v = '{16'(sat16(cx + ilx * r)), 16'(cy), 16'(sat16(cz + ilz * r)), 1'b0};
      expected_vertices.insert(expected_vertices.size(), v);
      v = '{16'(sat16(cx + irx * r)), 16'(cy), 16'(sat16(cz + irz * r)), 1'b0};
      expected_vertices.insert(expected_vertices.size(), v);
    end
    v = '{16'(cx), 16'(cy), 16'(cz), 1'b0};
    expected_vertices.insert(expected_vertices.size(), v);
    v.strip_end = 1'b1;
    expected_vertices.insert(expected_vertices.size(), v);
  endtask

  always @(posedge clk) begin
    vertex_t e, a;
    if (!rst_n) begin
      slices         = SLICE_COUNT_RST;
      intervals      = INTERVAL_COUNT_RST;
      reverse        = 1'b0;
      mismatch_count = 0;
      expected_vertices.delete();
    end else begin
      if (out_valid && !out_stall) begin
        a = '{out_vertex_x, out_vertex_y, out_vertex_z, out_strip_end};
        if (expected_vertices.size() == 0) begin
          mismatch_count++;
          $display("%0t unexpected vertex %h", $time, a);
        end else begin
          e = expected_vertices.pop_front();
          if (a !== e) begin
            mismatch_count++;
            $display({"%0t vertex mismatch: expected x=%0d y=%0d z=%0d end=%b,",
                      " actual x=%0d y=%0d z=%0d end=%b"},
                     $time, e.x, e.y, e.z, e.strip_end, a.x, a.y, a.z, a.strip_end);
          end
        end
      end
      if (in_valid && !in_stall)
        predict_wedge(in_center_x, in_center_y, in_center_z, in_disc_radius,
                      in_slice_index);
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'd0) begin
        case (paddr[3:2])
          REG_SLICE_COUNT:     slices    = pwdata[12:0];
          REG_INTERVAL_COUNT:  intervals = pwdata[4:0];
          REG_REVERSE_WINDING: reverse   = pwdata[0];
          default: ;
        endcase
      end
    end
    vertices_pending = expected_vertices.size();
  end

endmodule

// ===== sim/disc_slice_strip_generator_test.sv =====
module disc_slice_strip_generator_test;
  import dssg_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_center_x = '0;
  logic signed [15:0] in_center_y = '0;
  logic signed [15:0] in_center_z = '0;
  logic [14:0]        in_disc_radius = '0;
  logic [11:0]        in_slice_index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_vertex_x, out_vertex_y, out_vertex_z;
  logic               out_strip_end;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int mismatch_count, vertices_pending;
  // no random idling on either side while set
  bit no_idle = 1'b0;

  always #4 clk = ~clk;

  disc_slice_strip_generator i_dut (.*);

  dssg_strip_checker i_checker (.*);

  // result side back-pressure, changed on the falling edge
  always @(negedge clk)
    out_stall = !no_idle && ($urandom_range(99) < 12);

  // APB write: setup cycle, then access cycle
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // drain all outstanding vertices before touching registers
  task automatic wait_drained();
    while (vertices_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // one wedge transaction; valid held through stall, gaps at random
  task automatic send_wedge(input logic [15:0] cx, input logic [15:0] cy,
                            input logic [15:0] cz, input logic [14:0] rad,
                            input logic [11:0] k);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 12) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_center_x = cx; in_center_y = cy; in_center_z = cz;
    in_disc_radius = rad; in_slice_index = k;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // random wedge: mostly in-range index, sometimes small radius
  task automatic send_random(input int n);
    logic [14:0] rad;
    logic [11:0] k;
    rad = ($urandom_range(3) == 0) ? 15'($urandom_range(255)) : 15'($urandom);
    k = ($urandom_range(3) == 0 || n < 2) ? 12'($urandom) : 12'($urandom_range(n - 1));
    send_wedge(16'($urandom), 16'($urandom), 16'($urandom), rad, k);
  endtask

  initial begin
    int slice_set[6] = '{1, 4096, 0, 8191, 3, 7};
    int ivl_set[6]   = '{1, 30, 0, 31, 7, 13};
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // directed, default registers: extremes, wrap at the last wedge, saturation
    send_wedge(16'h0000, 16'h0000, 16'h0000, 15'd0,      12'd0);
    send_wedge(16'h0000, 16'h1234, 16'h0000, 15'h7FFF,   12'd0);
    send_wedge(16'h0000, 16'h0000, 16'h0000, 15'h7FFF,   12'd3);
    send_wedge(16'h0000, 16'h0000, 16'h0000, 15'h7FFF,   12'd15);
    send_wedge(16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h7FFF,   12'd1);
    send_wedge(16'h8000, 16'h8000, 16'h8000, 15'h7FFF,   12'd9);
    send_wedge(16'h7FFF, 16'h8000, 16'h8000, 15'h7FFF,   12'd5);
    send_wedge(16'h8000, 16'hFFFF, 16'h7FFF, 15'h7FFF,   12'd12);
    send_wedge(16'hFFFF, 16'h5555, 16'hAAAA, 15'd1,      12'd4095);
    send_wedge(16'h5555, 16'hAAAA, 16'h5555, 15'h2AAA,   12'd2048);
    send_wedge(16'h00FF, 16'h0100, 16'hFF00, 15'h5555,   12'hAAA);
    send_wedge(16'h1000, 16'h0000, 16'hF000, 15'd3,      12'h555);
    wait_drained();

    // write the reverse-winding register, unknown register index too
    reg_write(REG_REVERSE_WINDING, 32'd1);
    reg_write(2'd3, 32'hFFFF_FFFF);
    wait_drained();
    send_wedge(16'h0000, 16'h0000, 16'h0000, 15'h7FFF, 12'd2);
    send_wedge(16'h7FFF, 16'h0000, 16'h8000, 15'h7FFF, 12'd15);

    // settings sweep: single wedge, max wedges, zero counts, counts above range
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      reg_write(REG_SLICE_COUNT,     32'(slice_set[p]) | ($urandom & 32'hFFFF_E000));
      reg_write(REG_INTERVAL_COUNT,  32'(ivl_set[p]));
      reg_write(REG_REVERSE_WINDING, 32'(p % 2));
      no_idle = (p == 2);
      for (int i = 0; i < 45; i++)
        send_random(slice_set[p] == 0 ? 1 : (slice_set[p] > 4096 ? 4096 : slice_set[p]));
    end
    no_idle = 1'b0;

    // fully random registers
    for (int p = 0; p < 4; p++) begin
      int n;
      wait_drained();
      n = $urandom_range(1, 4096);
      reg_write(REG_SLICE_COUNT,     32'(n));
      reg_write(REG_INTERVAL_COUNT,  $urandom);
      reg_write(REG_REVERSE_WINDING, $urandom);
      for (int i = 0; i < 25; i++)
        send_random(n);
    end

    wait_drained();
    repeat (100) @(negedge clk);
    if (mismatch_count == 0 && vertices_pending == 0)
      $display("disc_slice_strip_generator verification clean");
    else
      $display("disc_slice_strip_generator verification failed");
    $finish;
  end

  // watchdog
  initial begin
    #40000000;
    $display("disc_slice_strip_generator verification failed");
    $finish;
  end
endmodule
